@@ rtl/core/mtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared constants and types of the MRU tag cache directory.
// ----------------------------------------------------------------------------
package mtc_pkg;

    localparam int TAG_W         = 32;
    localparam int OUT_W         = 6;
    localparam int DEFAULT_SLOTS = 64;

    localparam logic [TAG_W-1:0] RESET_TAG = 32'h7fff_ffff;

    // Command codes carried in the input tuser.
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_PROBE  = 1'b1;

    // Control for one cell of the recency chain.
    typedef struct packed {
        logic cmp_en;    // capture the compare result against the incoming key
        logic shift_en;  // take the entry of the left neighbor
    } cell_ctrl_t;

endpackage

@@ rtl/core/mtc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_cell
// One recency position: holds a slot number and its key, compares the key
// against an incoming lookup and hands its entry to the right neighbor.
// ----------------------------------------------------------------------------
module mtc_cell #(
    parameter int NUM_SLOTS  = mtc_pkg::DEFAULT_SLOTS,
    parameter int SLOT_W     = 6,
    parameter int RESET_SLOT = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mtc_pkg::cell_ctrl_t      ctrl,
    input  logic [mtc_pkg::TAG_W-1:0] cmp_x,
    input  logic [mtc_pkg::TAG_W-1:0] cmp_z,
    input  logic [SLOT_W-1:0]        prev_slot,
    input  logic [mtc_pkg::TAG_W-1:0] prev_x,
    input  logic [mtc_pkg::TAG_W-1:0] prev_z,
    output logic [SLOT_W-1:0]        cur_slot,
    output logic [mtc_pkg::TAG_W-1:0] cur_x,
    output logic [mtc_pkg::TAG_W-1:0] cur_z,
    output logic                     match,
    output logic [NUM_SLOTS-1:0]     slot_hot
);
    import mtc_pkg::*;

    logic [SLOT_W-1:0] slot_reg;
    logic [TAG_W-1:0]  x_reg;
    logic [TAG_W-1:0]  z_reg;
    logic              match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_W'(RESET_SLOT);
            x_reg    <= RESET_TAG;
            z_reg    <= RESET_TAG;
        end
        else if (ctrl.shift_en)
        begin
            slot_reg <= prev_slot;
            x_reg    <= prev_x;
            z_reg    <= prev_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            match_reg <= (x_reg == cmp_x) && (z_reg == cmp_z);
        end
    end

    // Matching slot as a one-hot vector indexed by slot number.
    always_comb
    begin
        slot_hot           = '0;
        slot_hot[slot_reg] = match_reg;
    end

    assign cur_slot = slot_reg;
    assign cur_x    = x_reg;
    assign cur_z    = z_reg;
    assign match    = match_reg;

endmodule

@@ rtl/core/mru_tag_cache_policy_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_tag_cache_policy_core
// Fully associative cache directory with move-to-front replacement, built
// as a chain of recency cells that each hold a slot number and its key.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tuser: cmd; tdata: key_x, key_z
//  m_*       out        tuser: hit; tdata: slot, order_position
//
//  An access compares the key in every cell on the input transfer and
//  shifts the chain in the update state. A probe registers the lowest
//  matching slot in the update state; the locate state then finds its
//  recency position. The final state waits while the output register is
//  full; the next transfer is taken the cycle after a result is loaded.
//  After reset cell i holds slot i with the key (0x7fffffff, 0x7fffffff).
// ----------------------------------------------------------------------------
module mru_tag_cache_policy_core #(
    parameter int CACHE_SLOTS = mtc_pkg::DEFAULT_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*mtc_pkg::TAG_W-1:0]   s_tdata,   // key_x, key_z
    input  logic                          s_tuser,   // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // slot, order_position, zero pad
    output logic                          m_tuser    // hit
);
    import mtc_pkg::*;

    localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(CACHE_SLOTS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_LOCATE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              cmd_reg;
    logic [TAG_W-1:0]  key_x_reg, key_z_reg;
    logic [SLOT_W-1:0] probe_slot_reg;
    logic              probe_hit_reg;

    logic              m_tvalid_reg;
    logic              res_hit_reg;
    logic [OUT_W-1:0]  res_slot_reg, res_pos_reg;

    logic [SLOT_W-1:0]      cell_slot [CACHE_SLOTS];
    logic [TAG_W-1:0]       cell_x    [CACHE_SLOTS];
    logic [TAG_W-1:0]       cell_z    [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] cell_hot  [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] match_vec;
    cell_ctrl_t             cell_ctrl [CACHE_SLOTS];

    logic                   in_fire, out_free, access_fire, locate_fire;
    logic [CACHE_SLOTS-1:0] first_mask;
    logic                   any_match;
    logic [SLOT_W-1:0]      hit_pos, hit_slot, upd_pos, upd_slot;
    logic [CACHE_SLOTS-1:0] slot_hits, lowest_hit;
    logic [SLOT_W-1:0]      probe_slot;
    logic [SLOT_W-1:0]      loc_pos;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign access_fire = (state_reg == ST_UPDATE) && (cmd_reg == CMD_ACCESS) && out_free;
    assign locate_fire = (state_reg == ST_LOCATE) && out_free;

    // The chain: cell 0 takes the entry moved to the front, whose key is
    // always the looked-up key (unchanged on a hit, newly written on a miss).
    for (genvar i = 0; i < CACHE_SLOTS; i++)
    begin : g_cell
        assign cell_ctrl[i].cmp_en   = in_fire;
        assign cell_ctrl[i].shift_en = access_fire && (SLOT_W'(i) <= upd_pos);

        if (i == 0)
        begin : g_front
            mtc_cell #(
                .NUM_SLOTS  (CACHE_SLOTS),
                .SLOT_W     (SLOT_W),
                .RESET_SLOT (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[i]),
                .cmp_x     (s_tdata[TAG_W-1:0]),
                .cmp_z     (s_tdata[2*TAG_W-1:TAG_W]),
                .prev_slot (upd_slot),
                .prev_x    (key_x_reg),
                .prev_z    (key_z_reg),
                .cur_slot  (cell_slot[i]),
                .cur_x     (cell_x[i]),
                .cur_z     (cell_z[i]),
                .match     (match_vec[i]),
                .slot_hot  (cell_hot[i])
            );
        end
        else
        begin : g_rest
            mtc_cell #(
                .NUM_SLOTS  (CACHE_SLOTS),
                .SLOT_W     (SLOT_W),
                .RESET_SLOT (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[i]),
                .cmp_x     (s_tdata[TAG_W-1:0]),
                .cmp_z     (s_tdata[2*TAG_W-1:TAG_W]),
                .prev_slot (cell_slot[i-1]),
                .prev_x    (cell_x[i-1]),
                .prev_z    (cell_z[i-1]),
                .cur_slot  (cell_slot[i]),
                .cur_x     (cell_x[i]),
                .cur_z     (cell_z[i]),
                .match     (match_vec[i]),
                .slot_hot  (cell_hot[i])
            );
        end
    end

    // Access: first matching cell in recency order.
    assign first_mask = match_vec & (~match_vec + CACHE_SLOTS'(1));
    assign any_match  = |match_vec;

    always_comb
    begin
        hit_pos  = '0;
        hit_slot = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (first_mask[i])
            begin
                hit_pos  = hit_pos | SLOT_W'(i);
                hit_slot = hit_slot | cell_slot[i];
            end
        end
    end

    assign upd_pos  = any_match ? hit_pos : LAST_POS;
    assign upd_slot = any_match ? hit_slot : cell_slot[CACHE_SLOTS-1];

    // Probe: lowest matching slot number.
    always_comb
    begin
        slot_hits = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            slot_hits = slot_hits | cell_hot[i];
        end
    end

    assign lowest_hit = slot_hits & (~slot_hits + CACHE_SLOTS'(1));

    always_comb
    begin
        probe_slot = '0;
        for (int s = 0; s < CACHE_SLOTS; s++)
        begin
            if (lowest_hit[s])
            begin
                probe_slot = probe_slot | SLOT_W'(s);
            end
        end
    end

    // Probe: recency position of that slot; slot numbers are unique in the chain.
    always_comb
    begin
        loc_pos = '0;
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            if (cell_slot[i] == probe_slot_reg)
            begin
                loc_pos = loc_pos | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (cmd_reg == CMD_PROBE)
                begin
                    state_next = ST_LOCATE;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOCATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (access_fire || locate_fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= s_tuser;
            key_x_reg <= s_tdata[TAG_W-1:0];
            key_z_reg <= s_tdata[2*TAG_W-1:TAG_W];
        end
        if ((state_reg == ST_UPDATE) && (cmd_reg == CMD_PROBE))
        begin
            probe_slot_reg <= probe_slot;
            probe_hit_reg  <= |slot_hits;
        end
        if (access_fire)
        begin
            res_hit_reg  <= any_match;
            res_slot_reg <= OUT_W'(upd_slot);
            res_pos_reg  <= OUT_W'(upd_pos);
        end
        else if (locate_fire)
        begin
            res_hit_reg  <= probe_hit_reg;
            res_slot_reg <= probe_hit_reg ? OUT_W'(probe_slot_reg) : '0;
            res_pos_reg  <= probe_hit_reg ? OUT_W'(loc_pos) : OUT_W'(LAST_POS);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = res_hit_reg;
    assign m_tdata  = {{(16 - 2*OUT_W){1'b0}}, res_pos_reg, res_slot_reg};

endmodule

@@ test/mru_directory_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mru_directory_checker
// Watches both channels of the cache directory. It keeps its own tags and
// recency order, predicts the lookup result of every accepted transfer and
// compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module mru_directory_checker #(
    parameter int CACHE_SLOTS = mtc_pkg::DEFAULT_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [2*mtc_pkg::TAG_W-1:0]   s_tdata,   // key_x, key_z
    input  logic                          s_tuser,   // cmd
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,   // slot, order_position, zero pad
    input  logic                          m_tuser,   // hit
    output int                            error_count,
    output int                            pending
);

    localparam int OW = mtc_pkg::OUT_W;
    localparam int TW = mtc_pkg::TAG_W;
    localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

    typedef logic [TW-1:0] tag_t;

    typedef struct packed {
        logic          hit;
        logic [OW-1:0] slot;
        logic [OW-1:0] position;
    } lookup_t;

    logic [SW-1:0] recency [CACHE_SLOTS];
    tag_t          tag_x   [CACHE_SLOTS];
    tag_t          tag_z   [CACHE_SLOTS];
    lookup_t       lookup_q[$];

    task automatic clear_directory();
        int i;
        for (i = 0; i < CACHE_SLOTS; i++)
        begin
            recency[i] = SW'(i);
            tag_x[i]   = mtc_pkg::RESET_TAG;
            tag_z[i]   = mtc_pkg::RESET_TAG;
        end
    endtask

    // Looks up one key and applies the move-to-front update of an access.
    task automatic resolve_lookup(input logic cmd, input tag_t kx, input tag_t kz,
                                  output lookup_t res);
        int i;
        int pos;
        int s;
        logic [SW-1:0] moved;
        res.hit = 1'b0;
        pos     = CACHE_SLOTS - 1;
        s       = 0;
        if (cmd == mtc_pkg::CMD_ACCESS)
        begin
            for (i = 0; i < CACHE_SLOTS && !res.hit; i++)
            begin
                if (tag_x[recency[i]] == kx && tag_z[recency[i]] == kz)
                begin
                    res.hit = 1'b1;
                    pos     = i;
                    s       = int'(recency[i]);
                end
            end
            if (!res.hit)
                s = int'(recency[CACHE_SLOTS-1]);
            moved = recency[pos];
            for (i = pos; i > 0; i--)
                recency[i] = recency[i-1];
            recency[0] = moved;
            if (!res.hit)
            begin
                tag_x[s] = kx;
                tag_z[s] = kz;
            end
        end
        else
        begin
            // A probe scans in slot order and leaves the state untouched.
            for (i = 0; i < CACHE_SLOTS && !res.hit; i++)
            begin
                if (tag_x[i] == kx && tag_z[i] == kz)
                begin
                    res.hit = 1'b1;
                    s       = i;
                end
            end
            if (res.hit)
            begin
                for (i = 0; i < CACHE_SLOTS; i++)
                    if (int'(recency[i]) == s)
                        pos = i;
            end
        end
        res.slot     = s[OW-1:0];
        res.position = pos[OW-1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t predicted;
        lookup_t returned;
        if (!rst_n)
        begin
            clear_directory();
            lookup_q.delete();
            error_count = 0;
            pending     = 0;
        end
        else
        begin
            // The result side is handled first: a result can never belong to
            // the transfer accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                returned.hit      = m_tuser;
                returned.slot     = m_tdata[OW-1:0];
                returned.position = m_tdata[2*OW-1:OW];
                if (lookup_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result hit=%0d slot=%0d position=%0d",
                                 $realtime, returned.hit, returned.slot, returned.position);
                end
                else
                begin
                    predicted = lookup_q.pop_front();
                    if (returned !== predicted)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $write("%0t: mismatch, expected hit=%0d slot=%0d position=%0d,",
                                   $realtime, predicted.hit, predicted.slot,
                                   predicted.position);
                            $display(" got hit=%0d slot=%0d position=%0d",
                                     returned.hit, returned.slot, returned.position);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                resolve_lookup(s_tuser, s_tdata[TW-1:0], s_tdata[2*TW-1:TW], predicted);
                lookup_q.push_back(predicted);
            end
            pending = lookup_q.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lookups into the cache directory: a directed opening around the
// reset key, duplicate tags, extreme coordinates and probe misses, then
// random phases over key pools of varied size so that hits, evictions and
// probes at every recency depth occur. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CACHE_SLOTS = mtc_pkg::DEFAULT_SLOTS;
    localparam int TW          = mtc_pkg::TAG_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int POOL_MAX    = 128;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [2*TW-1:0]   s_tdata  = '0;
    logic              s_tuser  = mtc_pkg::CMD_ACCESS;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;

    int error_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;

    logic [TW-1:0] pool_x[POOL_MAX];
    logic [TW-1:0] pool_z[POOL_MAX];

    mru_tag_cache_policy_core #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mru_directory_checker #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates near zero and near both ends of the signed range collide
    // often enough to give partial tag matches.
    function automatic logic [TW-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        else if (r < 7)
            return TW'($urandom_range(0, 16)) - TW'(8);
        else if (r < 8)
            return 32'h8000_0000 + TW'($urandom_range(0, 3));
        return mtc_pkg::RESET_TAG - TW'($urandom_range(0, 3));
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!sink_steady)
                stall_left = idle_length();
        end
    end

    // Called right after the rising edge of the previous transfer.
    task automatic send_lookup(input logic cmd, input logic [TW-1:0] kx,
                               input logic [TW-1:0] kz);
        int gap;
        gap = src_steady ? 0 : idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {kz, kx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        int r;
        int pool_size;
        int idx;
        logic cmd;
        logic [TW-1:0] kx;
        logic [TW-1:0] kz;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every slot starts with the reset key, so it hits from the start.
        send_lookup(mtc_pkg::CMD_PROBE,  mtc_pkg::RESET_TAG, mtc_pkg::RESET_TAG);
        send_lookup(mtc_pkg::CMD_ACCESS, mtc_pkg::RESET_TAG, mtc_pkg::RESET_TAG);
        send_lookup(mtc_pkg::CMD_PROBE,  32'h0000_0000, 32'h0000_0000);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000);
        // The reset key now sits in many slots but not in the front one.
        send_lookup(mtc_pkg::CMD_ACCESS, mtc_pkg::RESET_TAG, mtc_pkg::RESET_TAG);
        send_lookup(mtc_pkg::CMD_PROBE,  mtc_pkg::RESET_TAG, mtc_pkg::RESET_TAG);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h8000_0000, 32'h8000_0000);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'hffff_ffff, 32'hffff_ffff);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h7fff_ffff, 32'h8000_0000);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h8000_0000, 32'h7fff_ffff);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h0000_0000, 32'hffff_ffff);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'hffff_ffff, 32'h0000_0000);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h7fff_ffff, 32'h0000_0000);
        send_lookup(mtc_pkg::CMD_PROBE,  32'h0000_0000, 32'h0000_0000);
        send_lookup(mtc_pkg::CMD_PROBE,  32'h8000_0000, 32'h8000_0000);
        send_lookup(mtc_pkg::CMD_PROBE,  32'h0000_0000, 32'h8000_0000);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h8000_0000, 32'h8000_0000);
        send_lookup(mtc_pkg::CMD_PROBE,  32'hffff_ffff, 32'hffff_ffff);
        send_lookup(mtc_pkg::CMD_PROBE,  32'h5555_5555, 32'haaaa_aaaa);
        send_lookup(mtc_pkg::CMD_ACCESS, 32'h5555_5555, 32'haaaa_aaaa);
        send_lookup(mtc_pkg::CMD_PROBE,  32'h5555_5555, 32'haaaa_aaaa);

        // Pools around the slot count give a mix of hits and evictions.
        for (phase = 0; phase < 19; phase++)
        begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            pool_size   = $urandom_range(4, POOL_MAX);
            for (n = 0; n < pool_size; n++)
            begin
                pool_x[n] = pick_coord();
                pool_z[n] = pick_coord();
                if (n > 0 && $urandom_range(0, 7) == 0)
                    pool_z[n] = pool_z[n-1];
            end
            for (n = 0; n < 100; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                begin
                    kx = $urandom;
                    kz = $urandom;
                end
                else if (r < 9)
                begin
                    kx = mtc_pkg::RESET_TAG;
                    kz = mtc_pkg::RESET_TAG;
                end
                else
                begin
                    idx = $urandom_range(0, pool_size - 1);
                    kx  = pool_x[idx];
                    kz  = pool_z[idx];
                end
                cmd = ($urandom_range(0, 9) < 3) ? mtc_pkg::CMD_PROBE : mtc_pkg::CMD_ACCESS;
                send_lookup(cmd, kx, kz);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
